/* sv/dsf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and segment codes of the DLE character-stuffing framer.
// No dependencies; imported by every module of the block.
package dsf_pkg;

    // Frame length bound at which the payload index saturates
    localparam int MAX_FRAME_LEN = 1024;
    localparam int IDX_W         = $clog2(MAX_FRAME_LEN + 1);

    // Field and register widths
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int CMP_W      = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_POSITION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_CHAR     = 1'b1;

    // Framing characters
    localparam logic [CHAR_W-1:0] CH_D = 8'h64;
    localparam logic [CHAR_W-1:0] CH_L = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_E = 8'h65;
    localparam logic [CHAR_W-1:0] CH_S = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T = 8'h74;
    localparam logic [CHAR_W-1:0] CH_X = 8'h78;

    // Output segments of one job, in emission order (bit positions of the job mask)
    localparam int SEG_N    = 10;
    localparam int SEG_W    = $clog2(SEG_N);
    localparam int SEG_HDR  = 0;  // dle stx
    localparam int SEG_INS0 = 1;  // dle char dle before byte 0
    localparam int SEG_STF  = 2;  // extra dle before byte 0
    localparam int SEG_B0   = 3;
    localparam int SEG_INS1 = 4;
    localparam int SEG_B1   = 5;
    localparam int SEG_INS2 = 6;
    localparam int SEG_B2   = 7;
    localparam int SEG_ENDI = 8;  // insertion after the last byte
    localparam int SEG_TRL  = 9;  // dle etx

    // Job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [SEG_N-1:0]           mask;
        logic [2:0][CHAR_W-1:0]     bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* sv/dsf_front.sv */
`timescale 1ns / 1ps
// Front part of the framer: accepts payload bytes, keeps the lookahead window
// and turns each item into a job descriptor. Depends on dsf_pkg.
module dsf_front import dsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CHAR_W-1:0] i_payload_byte,
    input  logic             i_frame_end,
    input  logic [POS_W-1:0] i_insert_position,
    input  t_q_status        i_q_status,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_LEN);

    logic [1:0][CHAR_W-1:0] r_held, n_held;
    logic [1:0]             r_cnt, n_cnt;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_hdr_sent, n_hdr_sent;

    logic [2:0][CHAR_W-1:0] w_buf;
    logic [1:0]             w_len;
    logic [2:0]             w_emit;
    logic [3:0][IDX_W-1:0]  w_pidx;
    logic [2:0]             w_ins;
    logic                   w_acc;
    logic                   w_stuff;
    logic                   w_endins;
    logic [SEG_N-1:0]       w_mask;

    function automatic logic pos_hit(input logic [IDX_W-1:0] idx,
                                     input logic [POS_W-1:0] pos);
        pos_hit = (CMP_W'(idx) + CMP_W'(1)) == CMP_W'(pos);
    endfunction

    assign w_acc      = i_in_valid && !i_q_status.full;
    assign o_in_ready = !i_q_status.full;

    always_comb begin
        w_buf        = '0;
        w_buf[0]     = r_held[0];
        w_buf[1]     = r_held[1];
        w_buf[r_cnt] = i_payload_byte;
        w_len        = r_cnt + 2'd1;

        for (int k = 0; k < 3; k++) begin
            if (i_frame_end) begin
                w_emit[k] = (2'(k) < w_len);
            end else begin
                w_emit[k] = (k == 0) && (w_len == 2'd3);
            end
        end

        // Payload index seen by each emitted byte, saturating at the bound
        w_pidx[0] = r_idx;
        for (int k = 0; k < 3; k++) begin
            if (w_emit[k] && (w_pidx[k] < IDX_MAX)) begin
                w_pidx[k+1] = w_pidx[k] + IDX_W'(1);
            end else begin
                w_pidx[k+1] = w_pidx[k];
            end
        end

        for (int k = 0; k < 3; k++) begin
            w_ins[k] = w_emit[k] && (w_pidx[k] < IDX_MAX) &&
                       pos_hit(w_pidx[k], i_insert_position);
        end

        w_stuff  = w_emit[0] && (w_len == 2'd3) &&
                   (w_buf[0] == CH_D) && (w_buf[1] == CH_L) && (w_buf[2] == CH_E);
        w_endins = i_frame_end && pos_hit(w_pidx[3], i_insert_position);

        w_mask           = '0;
        w_mask[SEG_HDR]  = !r_hdr_sent;
        w_mask[SEG_INS0] = w_ins[0];
        w_mask[SEG_STF]  = w_stuff;
        w_mask[SEG_B0]   = w_emit[0];
        w_mask[SEG_INS1] = w_ins[1];
        w_mask[SEG_B1]   = w_emit[1];
        w_mask[SEG_INS2] = w_ins[2];
        w_mask[SEG_B2]   = w_emit[2];
        w_mask[SEG_ENDI] = w_endins;
        w_mask[SEG_TRL]  = i_frame_end;
    end

    assign o_job.mask  = w_mask;
    assign o_job.bytes = w_buf;
    assign o_push      = w_acc && (w_mask != '0);

    always_comb begin
        n_held     = r_held;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_hdr_sent = r_hdr_sent;
        if (w_acc) begin
            if (i_frame_end) begin
                n_held     = '0;
                n_cnt      = 2'd0;
                n_idx      = '0;
                n_hdr_sent = 1'b0;
            end else if (w_len == 2'd3) begin
                n_held[0]  = w_buf[1];
                n_held[1]  = w_buf[2];
                n_cnt      = 2'd2;
                n_idx      = w_pidx[3];
                n_hdr_sent = 1'b1;
            end else begin
                n_held[0]  = w_buf[0];
                n_held[1]  = w_buf[1];
                n_cnt      = w_len;
                n_hdr_sent = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_cnt      <= 2'd0;
            r_idx      <= '0;
            r_hdr_sent <= 1'b0;
        end else begin
            r_held     <= n_held;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_hdr_sent <= n_hdr_sent;
        end
    end

endmodule

/* sv/dsf_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front and back parts of the framer.
// Depends on dsf_pkg for the job type and depth.
module dsf_queue import dsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    t_job                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, n_wr;
    logic [Q_PTR_W-1:0]  r_rd, n_rd;
    logic [Q_CNT_W-1:0]  r_count, n_count;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + Q_PTR_W'(1);
        end
    endfunction

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd    = i_pop  ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full job queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty job queue");
`endif

endmodule

/* sv/dsf_back.sv */
`timescale 1ns / 1ps
// Back part of the framer: expands one job a time into output bytes through
// a segment sequencer and an output register. Depends on dsf_pkg.
module dsf_back import dsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    input  logic [CHAR_W-1:0] i_insert_char,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_out_byte,
    output logic              o_run_last,
    output logic              o_frame_done
);

    logic [SEG_N-1:0]       r_mask, n_mask;
    logic [2:0][CHAR_W-1:0] r_bytes, n_bytes;
    logic [2:0]             r_off, n_off;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_out_byte, n_out_byte;
    logic                   r_run_last, n_run_last;
    logic                   r_frame_done, n_frame_done;

    logic [SEG_W-1:0]       w_cur;
    logic [SEG_N-1:0]       w_rest;
    logic                   w_seg_end;
    logic                   w_job_last;
    logic                   w_go;
    logic                   w_load;

    function automatic logic [2:0] seg_last(input logic [SEG_W-1:0] seg);
        case (seg)
            SEG_W'(SEG_HDR), SEG_W'(SEG_TRL):                  seg_last = 3'd5;
            SEG_W'(SEG_INS0), SEG_W'(SEG_INS1),
            SEG_W'(SEG_INS2), SEG_W'(SEG_ENDI):                seg_last = 3'd6;
            SEG_W'(SEG_STF):                                   seg_last = 3'd2;
            default:                                           seg_last = 3'd0;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] seg_byte(input logic [SEG_W-1:0]       seg,
                                                   input logic [2:0]             off,
                                                   input logic [2:0][CHAR_W-1:0] b,
                                                   input logic [CHAR_W-1:0]      ch);
        logic [CHAR_W-1:0] dle;
        logic [CHAR_W-1:0] tail;
        dle = (off[1:0] == 2'd0) ? CH_D : ((off[1:0] == 2'd1) ? CH_L : CH_E);
        case (off)
            3'd3:    tail = (seg == SEG_W'(SEG_HDR)) ? CH_S : CH_E;
            3'd4:    tail = CH_T;
            default: tail = CH_X;
        endcase
        case (seg)
            SEG_W'(SEG_HDR), SEG_W'(SEG_TRL): begin
                seg_byte = (off < 3'd3) ? dle : tail;
            end
            SEG_W'(SEG_INS0), SEG_W'(SEG_INS1), SEG_W'(SEG_INS2), SEG_W'(SEG_ENDI): begin
                if (off == 3'd3) begin
                    seg_byte = ch;
                end else if (off < 3'd3) begin
                    seg_byte = dle;
                end else begin
                    seg_byte = (off == 3'd4) ? CH_D : ((off == 3'd5) ? CH_L : CH_E);
                end
            end
            SEG_W'(SEG_STF): seg_byte = dle;
            SEG_W'(SEG_B0):  seg_byte = b[0];
            SEG_W'(SEG_B1):  seg_byte = b[1];
            SEG_W'(SEG_B2):  seg_byte = b[2];
            default:         seg_byte = b[0];
        endcase
    endfunction

    // Lowest pending segment is the one being emitted
    always_comb begin
        w_cur = '0;
        for (int i = SEG_N - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_cur = SEG_W'(i);
            end
        end
    end

    always_comb begin
        w_rest          = r_mask;
        w_rest[w_cur]   = 1'b0;
        w_seg_end       = (r_off == seg_last(w_cur));
        w_job_last      = w_seg_end && (w_rest == '0);
        w_go            = (r_mask != '0) && (!r_out_valid || i_out_ready);
        w_load          = (r_mask == '0) || (w_go && w_job_last);
    end

    assign o_pop = w_load && !i_q_status.empty;

    always_comb begin
        n_mask       = r_mask;
        n_bytes      = r_bytes;
        n_off        = r_off;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_run_last   = r_run_last;
        n_frame_done = r_frame_done;
        if (w_go) begin
            n_out_valid  = 1'b1;
            n_out_byte   = seg_byte(w_cur, r_off, r_bytes, i_insert_char);
            n_run_last   = w_job_last;
            n_frame_done = w_job_last && (w_cur == SEG_W'(SEG_TRL));
            if (w_seg_end) begin
                n_off  = 3'd0;
                n_mask = w_rest;
            end else begin
                n_off  = r_off + 3'd1;
            end
        end
        if (o_pop) begin
            n_mask  = i_job.mask;
            n_bytes = i_job.bytes;
            n_off   = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_off       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes      <= n_bytes;
        r_out_byte   <= n_out_byte;
        r_run_last   <= n_run_last;
        r_frame_done <= n_frame_done;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_frame_done = r_frame_done;

`ifndef ASSERT_OFF
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_done) |-> r_run_last)
        else $error("frame_done without run_last");
    a_offset_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != '0) |-> (r_off <= seg_last(w_cur)))
        else $error("segment offset beyond segment length");
    a_job_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mask != '0) && !w_go) |=> ($stable(r_mask) && $stable(r_off)))
        else $error("job advanced while output stalled");
`endif

endmodule

/* sv/dle_character_stuffing_framer.sv */
`timescale 1ns / 1ps
// Top level of the DLE/STX/ETX character-stuffing framer: configuration
// registers and the front, queue and back parts. Depends on dsf_pkg.
//
// Payload bytes go in one per transaction, the last of a frame flagged by
// frame_end; the stuffed frame comes out one byte per transaction. The first
// byte of a frame brings the header "dle stx", every "dle" sequence in the
// payload gets an extra "dle" before it, the sequence "dle", insert_char,
// "dle" goes before the payload byte at one-based insert_position (or after
// the last byte when the position is length + 1), and frame_end brings the
// trailer "dle etx", whose final byte carries frame_done. Two payload bytes
// are held back for the lookahead, so a transaction may cause no output;
// run_last marks the last output byte caused by each input transaction.
// Rate: the front takes one input transaction per cycle while the two-entry
// job queue has room; the back emits one output byte per cycle while the
// receiver is ready, so a transaction that causes N output bytes (0 to 20)
// holds the back until all N are out; the byte sequencer sets the sustained
// rate. An item passes a queue entry and the back's job register before it
// reaches the output register. Configuration is taken at any cycle (ready is
// always high) and is meant to be written while no frame bytes are in flight.
module dle_character_stuffing_framer import dsf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // payload input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAR_W-1:0]     i_payload_byte,
    input  logic                  i_frame_end,
    // stuffed output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAR_W-1:0]     o_out_byte,
    output logic                  o_run_last,
    output logic                  o_frame_done,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [POS_W-1:0]  r_insert_position, n_insert_position;
    logic [CHAR_W-1:0] r_insert_char, n_insert_char;

    logic              w_push;
    logic              w_pop;
    t_job              w_front_job;
    t_job              w_queue_job;
    t_q_status         w_q_status;

    // Configuration: always ready; unknown indexes drop the write
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_insert_position = r_insert_position;
        n_insert_char     = r_insert_char;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INSERT_POSITION: n_insert_position = i_cfg_data[POS_W-1:0];
                CFG_INSERT_CHAR:     n_insert_char     = i_cfg_data[CHAR_W-1:0];
                default: begin
                    n_insert_position = r_insert_position;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_insert_position <= POS_W'(1);
            r_insert_char     <= '0;
        end else begin
            r_insert_position <= n_insert_position;
            r_insert_char     <= n_insert_char;
        end
    end

    // Front: hold the lookahead window, classify each byte into a job
    dsf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_payload_byte    (i_payload_byte),
        .i_frame_end       (i_frame_end),
        .i_insert_position (r_insert_position),
        .i_q_status        (w_q_status),
        .o_push            (w_push),
        .o_job             (w_front_job)
    );

    // Queue: decouple classification from byte expansion
    dsf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_queue_job),
        .o_status (w_q_status)
    );

    // Back: expand each job into output bytes, one per cycle while the receiver is ready
    dsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_queue_job),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .i_insert_char (r_insert_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_frame_done  (o_frame_done)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the DLE/STX/ETX character-stuffing framer.
// Holds its own predictor, a queue-fed driver and an output monitor.
// Depends on dsf_pkg and dle_character_stuffing_framer only.
module tb;
    import dsf_pkg::*;

    // Run shape
    localparam int SETTLE_CYCLES = 8;     // quiet cycles before a register write
    localparam int TAIL_CYCLES   = 30;    // quiet cycles after the last byte
    localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
    localparam int LONG_HOLD     = 400;   // one long receiver hold-off
    localparam int RANDOM_ITEMS  = 400;
    localparam int LONG_FRAME    = 240;   // keeps the sender busy through the hold-off
    localparam int MISMATCH_LINES = 100;
    localparam logic [POS_W-1:0] POS_TOP = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              last;
    } t_payload;

    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              run_last;
        logic              frame_done;
    } t_stuffed;

    // DUT connections
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CHAR_W-1:0]     i_payload_byte;
    logic                  i_frame_end;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CHAR_W-1:0]     o_out_byte;
    logic                  o_run_last;
    logic                  o_frame_done;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Stimulus and expectations
    t_payload payload_q[$];   // bytes waiting to be offered
    t_stuffed stuffed_q[$];   // stuffed bytes still owed by the block
    t_stuffed step_out[$];    // bytes caused by the transaction being predicted
    t_payload next_item;

    // Predictor state: lookahead window, frame position, header flag, registers
    logic [CHAR_W-1:0] win_held [2];
    int                win_count;
    int                pay_count;
    bit                hdr_done;
    logic [POS_W-1:0]  cfg_pos;
    logic [CHAR_W-1:0] cfg_char;

    // Pacing and bookkeeping
    int in_gap, in_calm, out_gap, out_calm;
    int hold_left;
    bit hold_done;
    int idle_cycles;
    int mismatches;

    dle_character_stuffing_framer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_frame_done   (o_frame_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void put_char(logic [CHAR_W-1:0] c);
        t_stuffed s;
        s.data       = c;
        s.run_last   = 1'b0;
        s.frame_done = 1'b0;
        step_out.push_back(s);
    endfunction

    function automatic void put_dle();
        put_char(CH_D);
        put_char(CH_L);
        put_char(CH_E);
    endfunction

    function automatic void put_insertion();
        put_dle();
        put_char(cfg_char);
        put_dle();
    endfunction

    // Emit window byte k: insertion first, then the extra dle, then the byte.
    // Once the index saturates no insertion lands in front of a byte.
    function automatic void put_payload(logic [2:0][CHAR_W-1:0] win, int k, int len);
        if (pay_count < MAX_FRAME_LEN && cfg_pos != '0 && pay_count == int'(cfg_pos) - 1)
            put_insertion();
        if (k + 2 < len && win[k] == CH_D && win[k+1] == CH_L && win[k+2] == CH_E)
            put_dle();
        put_char(win[k]);
        if (pay_count < MAX_FRAME_LEN)
            pay_count++;
    endfunction

    // Work out every stuffed byte that one accepted payload transaction causes
    function automatic void stuff_step(logic [CHAR_W-1:0] b, logic last);
        logic [2:0][CHAR_W-1:0] win;
        int                     n;
        t_stuffed               s;
        step_out.delete();
        if (!hdr_done) begin
            put_dle();
            put_char(CH_S);
            put_char(CH_T);
            put_char(CH_X);
            hdr_done = 1'b1;
        end
        win            = '0;
        win[0]         = win_held[0];
        win[1]         = win_held[1];
        win[win_count] = b;
        n              = win_count + 1;
        if (last) begin
            // Flush the window; nothing past the frame end can complete a dle
            for (int k = 0; k < n; k++)
                put_payload(win, k, n);
            if (cfg_pos != '0 && int'(cfg_pos) == pay_count + 1)
                put_insertion();
            put_dle();
            put_char(CH_E);
            put_char(CH_T);
            put_char(CH_X);
            s = step_out.pop_back();
            s.frame_done = 1'b1;
            step_out.push_back(s);
            win_held[0] = '0;
            win_held[1] = '0;
            win_count   = 0;
            pay_count   = 0;
            hdr_done    = 1'b0;
        end else if (n == 3) begin
            put_payload(win, 0, n);
            win_held[0] = win[1];
            win_held[1] = win[2];
            win_count   = 2;
        end else begin
            win_held[0] = win[0];
            win_held[1] = win[1];
            win_count   = n;
        end
        if (step_out.size() > 0) begin
            s = step_out.pop_back();
            s.run_last = 1'b1;
            step_out.push_back(s);
        end
        foreach (step_out[i])
            stuffed_q.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MISMATCH_LINES)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_output(input logic [CHAR_W-1:0] b, input logic rl, input logic fd);
        t_stuffed want;
        if (stuffed_q.size() == 0) begin
            report_mismatch($sformatf("byte %02h arrived with nothing expected", b));
            return;
        end
        want = stuffed_q.pop_front();
        if (b !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", b, want.data));
        if (rl !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b (byte %02h)",
                                      rl, want.run_last, want.data));
        if (fd !== want.frame_done)
            report_mismatch($sformatf("frame_done %b, expected %b (byte %02h)",
                                      fd, want.frame_done, want.data));
    endtask

    // ------------------------------------------------------------------
    // Pacing: mostly back to back or short gaps, a few long ones, and now
    // and then a calm stretch with no gaps at all
    // ------------------------------------------------------------------
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued payload bytes, hold each until its transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                stuff_step(i_payload_byte, i_frame_end);
            // Only move on once the current byte has gone or none is offered
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (payload_q.size() > 0) begin
                    next_item = payload_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_payload_byte <= next_item.data;
                    i_frame_end    <= next_item.last;
                    in_gap = pick_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each output transaction, stall at random, and once
    // hold off for a long stretch while the sender keeps offering, so the
    // job queue fills and the input stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_output(o_out_byte, o_run_last, o_frame_done);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && payload_q.size() > 200 && i_in_valid) begin
                // Only the long frame keeps this many bytes queued
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready)
                    out_gap = pick_gap(out_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no channel moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_byte(logic [CHAR_W-1:0] b, logic last);
        t_payload p;
        p.data = b;
        p.last = last;
        payload_q.push_back(p);
    endfunction

    // Lean towards d, l and e so stuffing turns up often
    function automatic logic [CHAR_W-1:0] rand_char();
        case ($urandom_range(0, 9))
            0, 1:    return CH_D;
            2:       return CH_L;
            3:       return CH_E;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_frame(int len);
        int i;
        i = 0;
        while (i < len) begin
            if (i + 3 <= len && $urandom_range(0, 3) == 0) begin
                queue_byte(CH_D, 1'b0);
                queue_byte(CH_L, 1'b0);
                queue_byte(CH_E, i + 3 == len);
                i += 3;
            end else begin
                queue_byte(rand_char(), i + 1 == len);
                i++;
            end
        end
    endfunction

    // Positions around the frame length, the extremes and plain random
    function automatic logic [CFG_DATA_W-1:0] pick_position(int len);
        case ($urandom_range(0, 8))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(len);
            3:       return CFG_DATA_W'(len + 1);
            4:       return CFG_DATA_W'(len + 2);
            5:       return CFG_DATA_W'($urandom_range(1, len + 1));
            6:       return POS_TOP;
            7:       return CFG_DATA_W'(MAX_FRAME_LEN + 1);
            default: return CFG_DATA_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Wait for every byte to go in and every expected byte to come out,
    // then let the back end go quiet; a held byte causes no output
    task automatic settle();
        while (payload_q.size() != 0 || i_in_valid || stuffed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        // The write lands at this edge
        if (idx == CFG_INSERT_POSITION)
            cfg_pos = data[POS_W-1:0];
        else if (idx == CFG_INSERT_CHAR)
            cfg_char = data[CHAR_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int  sent;
        int  len;
        bit  long_done;
        sent        = 0;
        long_done   = 1'b0;
        win_held[0] = '0;
        win_held[1] = '0;
        win_count   = 0;
        pay_count   = 0;
        hdr_done    = 1'b0;
        cfg_pos     = POS_W'(1);
        cfg_char    = '0;
        in_gap      = 0;
        in_calm     = 0;
        out_gap     = 0;
        out_calm    = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        idle_cycles = 0;
        mismatches  = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_payload_byte <= '0;
        i_frame_end    <= 1'b0;
        i_out_ready    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_INSERT_POSITION;
        i_cfg_data     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: insert a zero character before a lone zero byte
        queue_byte(8'h00, 1'b1);
        settle();

        // Position zero: no insertion. A dle closing the frame still gets
        // stuffed; a dl cut short by the frame end does not
        write_reg(CFG_INSERT_POSITION, '0);
        write_reg(CFG_INSERT_CHAR, CFG_DATA_W'(8'hFF));
        queue_byte(CH_D, 1'b0);
        queue_byte(CH_L, 1'b0);
        queue_byte(CH_E, 1'b1);
        queue_byte(CH_D, 1'b0);
        queue_byte(CH_L, 1'b1);
        settle();

        // Insertion in front of the e of a stuffed dle, mid frame
        write_reg(CFG_INSERT_POSITION, 11'd4);
        write_reg(CFG_INSERT_CHAR, {3'b111, CH_D});
        queue_byte(8'h61, 1'b0);
        queue_byte(CH_D, 1'b0);
        queue_byte(CH_L, 1'b0);
        queue_byte(CH_E, 1'b0);
        queue_byte(CH_D, 1'b0);
        queue_byte(CH_L, 1'b0);
        queue_byte(CH_E, 1'b1);
        settle();

        // Position one past the last byte: insertion ahead of the trailer
        write_reg(CFG_INSERT_POSITION, 11'd3);
        write_reg(CFG_INSERT_CHAR, CFG_DATA_W'(8'hA5));
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b1);
        settle();

        // Highest position: out of range, nothing inserted
        write_reg(CFG_INSERT_POSITION, POS_TOP);
        queue_byte(8'h55, 1'b1);
        settle();

        // Register write with two bytes held back: the new position
        // applies to bytes emitted after it
        write_reg(CFG_INSERT_POSITION, 11'd3);
        queue_byte(CH_D, 1'b0);
        queue_byte(CH_L, 1'b0);
        settle();
        write_reg(CFG_INSERT_POSITION, 11'd1);
        write_reg(CFG_INSERT_CHAR, CFG_DATA_W'(8'h5A));
        queue_byte(CH_E, 1'b0);
        queue_byte(8'h01, 1'b1);
        settle();

        // Random frames, registers rewritten between frames now and then
        while (sent < RANDOM_ITEMS) begin
            if (!long_done && sent > 150) begin
                // Long frame: the receiver holds off once while it streams
                // in, so the job queue fills and the input stalls
                long_done = 1'b1;
                settle();
                write_reg(CFG_INSERT_POSITION, pick_position(LONG_FRAME));
                write_reg(CFG_INSERT_CHAR, CFG_DATA_W'($urandom_range(0, 2047)));
                queue_frame(LONG_FRAME);
                sent += LONG_FRAME;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            if ($urandom_range(0, 1) == 0) begin
                settle();
                if ($urandom_range(0, 2) != 0)
                    write_reg(CFG_INSERT_POSITION, pick_position(len));
                if ($urandom_range(0, 2) != 0)
                    write_reg(CFG_INSERT_CHAR, CFG_DATA_W'($urandom_range(0, 2047)));
            end
            queue_frame(len);
            sent += len;
        end

        // Drain, then give any stray output time to show up
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
